// ===== sv/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Build sizes, operation and status codes, beat structs and the control
// bundle that the top level broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int CAP_W      = 4;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
    logic                      ends_valid;
    logic                      now_full;
  } out_beat_t;

  // Control broadcast to every cell at once.
  typedef struct packed {
    logic             shift_right;  // push at the front: every entry moves up one
    logic             shift_left;   // pop at the front: every entry moves down one
    logic             load_rear;    // push at the rear: the cell at count loads
    logic [CNT_W-1:0] count;        // entries held before the operation
  } cell_ctrl_t;

endpackage

// ===== sv/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of the deque row
// Holds one entry and takes its neighbor's entry when the row shifts, or the
// pushed value when it sits right behind the current rear.
// ----------------------------------------------------------------------------
module cdq_cell
  import cdq_pkg::*;
(
  input  logic                  clk_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  output logic [DATA_WIDTH-1:0] data_d_o,
  output logic [DATA_WIDTH-1:0] data_q_o
);

  logic [DATA_WIDTH-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.shift_right) begin
      data_d = left_data_i;
    end else if (ctrl_i.shift_left) begin
      data_d = right_data_i;
    end else if (ctrl_i.load_rear && (CNT_W'(idx_i) == ctrl_i.count)) begin
      data_d = push_data_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_d_o = data_d;
  assign data_q_o = data_q;

endmodule

// ===== sv/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of DEPTH entries
// Push and pop at either end, with overflow and underflow reporting and the
// values at both ends returned with every operation.
// ----------------------------------------------------------------------------
// The deque takes one operation per clock cycle and returns exactly one result
// beat for each, in the cycle after the operation is accepted, from an output
// register. A new operation is accepted while the previous result is still
// being taken, as long as that result leaves this cycle; only a stalled result
// holds the input back. The entries live in a row of cells with the front
// always in cell zero: a push or pop at the front shifts the whole row by one
// place in that cycle, a push at the rear loads the cell just behind the last
// entry, and a pop at the rear only lowers the entry count. Writing the
// capacity register empties the deque at once; no clearing pass runs after
// reset, because a cell is never read before it was written. A capacity of
// zero acts as one and a capacity above DEPTH acts as DEPTH. Configuration may
// be written only while no operation is in flight.
// ----------------------------------------------------------------------------
module circular_deque
  import cdq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_beat_t         in_beat_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_beat_t        out_beat_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i
);

  // Control state: capacity register, entry count and output beat valid.
  logic [CAP_W-1:0] cap_d, cap_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic             out_valid_d, out_valid_q;
  out_beat_t        out_beat_d, out_beat_q;

  logic [CNT_W-1:0] cap_eff;
  logic             accept;
  logic             is_empty, is_full;
  status_e          status;
  cell_ctrl_t       ctrl;

  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] cell_d [DEPTH];
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [IDX_W-1:0]      rear_idx;

  // Clamp the capacity into the legal range of one to DEPTH.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_q) > DEPTH) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == cap_eff);
  assign push_data  = DATA_WIDTH'($unsigned(in_beat_i.push_value));

  // Decode the operation into the row control and the new entry count.
  always_comb begin
    ctrl.shift_right = 1'b0;
    ctrl.shift_left  = 1'b0;
    ctrl.load_rear   = 1'b0;
    ctrl.count       = count_q;
    count_d          = count_q;
    status           = ST_DONE;
    if (accept) begin
      unique case (in_beat_i.op)
        OP_PUSH_FRONT: begin
          if (is_full) begin
            status = ST_OVERFLOW;
          end else begin
            ctrl.shift_right = 1'b1;
            count_d          = count_q + 1'b1;
          end
        end
        OP_PUSH_REAR: begin
          if (is_full) begin
            status = ST_OVERFLOW;
          end else begin
            ctrl.load_rear = 1'b1;
            count_d        = count_q + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            status = ST_UNDERFLOW;
          end else begin
            ctrl.shift_left = 1'b1;
            count_d         = count_q - 1'b1;
          end
        end
        OP_POP_REAR: begin
          if (is_empty) begin
            status = ST_UNDERFLOW;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          status = ST_DONE;
        end
      endcase
    end
    // A capacity write empties the deque.
    if (cfg_we_i) begin
      count_d = '0;
    end
  end

  assign cap_d = cfg_we_i ? cfg_wdata_i : cap_q;

  // The row of cells. Cell zero holds the front; a front push feeds it the
  // pushed value, and the last cell sees its own entry on a left shift.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = push_data;
    end else begin : g_mid_l
      assign left_data = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_q[i];
    end else begin : g_mid_r
      assign right_data = cell_q[i+1];
    end

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (IDX_W'(i)),
      .ctrl_i       (ctrl),
      .push_data_i  (push_data),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .data_d_o     (cell_d[i]),
      .data_q_o     (cell_q[i])
    );
  end

  // The result reflects the deque after the operation: the front is the new
  // value of cell zero and the rear is the new value of the last held cell.
  assign rear_idx = IDX_W'(count_d - 1'b1);

  always_comb begin
    out_beat_d.status   = status;
    out_beat_d.now_full = (count_d == cap_eff);
    if (count_d == '0) begin
      out_beat_d.ends_valid  = 1'b0;
      out_beat_d.front_value = '0;
      out_beat_d.rear_value  = '0;
    end else begin
      out_beat_d.ends_valid  = 1'b1;
      out_beat_d.front_value = VALUE_W'(cell_d[0]);
      out_beat_d.rear_value  = VALUE_W'(cell_d[rear_idx]);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_W'(DEPTH);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

`ifndef SYNTH
  // The entry count never runs past the capacity in use.
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_eff)
    else $error("entry count exceeds capacity");

  // An overflow can only be reported while the deque is full.
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == ST_OVERFLOW) |-> out_beat_o.now_full)
    else $error("overflow reported on a deque that is not full");

  // An underflow can only be reported while the deque is empty.
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == ST_UNDERFLOW) |-> !out_beat_o.ends_valid)
    else $error("underflow reported on a deque that holds entries");

  // A successful push always leaves at least one entry behind.
  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cfg_we_i && (status == ST_DONE)
      && ((in_beat_i.op == OP_PUSH_FRONT) || (in_beat_i.op == OP_PUSH_REAR))
      |=> (count_q != '0))
    else $error("push left the deque empty");
`endif

endmodule

// ===== bench/circular_deque_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb: self-checking bench for the circular deque
// Pushes and pops at both ends go through the input channel under random
// gaps and output stalls. A behavioral copy of the deque predicts every
// result beat, and each one is checked field by field against the oldest
// prediction. The capacity register is written between phases.
// ----------------------------------------------------------------------------
module circular_deque_tb;
  import cdq_pkg::*;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_beat_t         in_beat_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_beat_t        out_beat_o;
  logic             cfg_we_i    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;

  circular_deque DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Operations waiting to be offered, and result beats predicted but not yet
  // seen on the output.
  in_beat_t  op_backlog[$];
  out_beat_t expected_results[$];
  int        mismatch_count = 0;

  // When set, neither side inserts gaps, so back-to-back beats are exercised.
  bit steady = 1'b0;

  // The stimulus process bumps this to ask the receiver for a long hold-off.
  int hold_requests = 0;

  // --------------------------------------------------------------------------
  // Behavioral copy of the deque. Indices move in a ring of the effective
  // capacity; the front is at head_at and the rear at tail_at.
  // --------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] ring_copy [DEPTH];
  int unsigned           head_at   = 0;
  int unsigned           tail_at   = 0;
  bit                    empty_now = 1'b1;
  logic [CAP_W-1:0]      cap_setting = CAP_W'(8);

  // A capacity of zero behaves as one, anything above DEPTH as DEPTH.
  function automatic int unsigned ring_size();
    if (cap_setting == 0) return 1;
    if (cap_setting > DEPTH) return DEPTH;
    return cap_setting;
  endfunction

  function automatic int unsigned ring_next(int unsigned i, int unsigned c);
    return (i + 1 >= c) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_prev(int unsigned i, int unsigned c);
    return (i == 0 || i >= c) ? c - 1 : i - 1;
  endfunction

  function automatic bit deque_is_full(int unsigned c);
    return !empty_now && ring_next(tail_at, c) == head_at;
  endfunction

  // Applies one operation to the copy and returns the beat the block owes.
  function automatic out_beat_t deque_step(in_beat_t b);
    int unsigned c;
    out_beat_t   r;
    c = ring_size();
    r = '0;
    r.status = ST_DONE;
    if (b.op == OP_PUSH_FRONT || b.op == OP_PUSH_REAR) begin
      if (deque_is_full(c)) begin
        r.status = ST_OVERFLOW;
      end else if (empty_now) begin
        head_at      = 0;
        tail_at      = 0;
        empty_now    = 1'b0;
        ring_copy[0] = b.push_value[DATA_WIDTH-1:0];
      end else if (b.op == OP_PUSH_FRONT) begin
        head_at            = ring_prev(head_at, c);
        ring_copy[head_at] = b.push_value[DATA_WIDTH-1:0];
      end else begin
        tail_at            = ring_next(tail_at, c);
        ring_copy[tail_at] = b.push_value[DATA_WIDTH-1:0];
      end
    end else begin
      if (empty_now) begin
        r.status = ST_UNDERFLOW;
      end else if (head_at == tail_at) begin
        head_at   = 0;
        tail_at   = 0;
        empty_now = 1'b1;
      end else if (b.op == OP_POP_FRONT) begin
        head_at = ring_next(head_at, c);
      end else begin
        tail_at = ring_prev(tail_at, c);
      end
    end
    // An empty deque reports both ends as zero with the valid flag low.
    if (!empty_now) begin
      r.front_value = ring_copy[head_at];
      r.rear_value  = ring_copy[tail_at];
      r.ends_valid  = 1'b1;
    end
    r.now_full = deque_is_full(c);
    return r;
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Valid is raised with the next backlog entry and held, payload
  // unchanged, until the block takes it. The prediction is made at the edge
  // where the beat is accepted.
  // --------------------------------------------------------------------------
  int send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_beat_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(deque_step(in_beat_i));
      end
      // The slot is free when nothing is offered or the offer just went in.
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (op_backlog.size() != 0) begin
          in_valid_i <= 1'b1;
          in_beat_i  <= op_backlog.pop_front();
          send_gap   <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Ready drops for random stretches. On request it also holds off
  // for a long, counted stretch while the sender keeps offering, so the
  // output register stays full and the block has to stall its input.
  // --------------------------------------------------------------------------
  int stall_left;
  int hold_left;
  int holds_served;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= 80;
      out_ready_i  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left  <= pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Checker. Every beat taken from the output is matched, field by field,
  // against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result beat with no operation outstanding: %p", out_beat_o);
      end else begin
        want = expected_results.pop_front();
        if (out_beat_o.status      !== want.status      ||
            out_beat_o.front_value !== want.front_value ||
            out_beat_o.rear_value  !== want.rear_value  ||
            out_beat_o.ends_valid  !== want.ends_valid  ||
            out_beat_o.now_full    !== want.now_full) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: status exp %0d got %0d, front exp %h got %h, rear exp %h got %h,",
                     want.status, out_beat_o.status, want.front_value,
                     out_beat_o.front_value, want.rear_value, out_beat_o.rear_value);
            $display("       ends_valid exp %0b got %0b, now_full exp %0b got %0b",
                     want.ends_valid, out_beat_o.ends_valid, want.now_full,
                     out_beat_o.now_full);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_op(op_e op, logic [VALUE_W-1:0] value);
    in_beat_t item;
    item.op         = op;
    item.push_value = value;
    op_backlog.push_back(item);
  endtask

  // Returns once everything offered has been accepted and answered.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (op_backlog.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Writing the capacity also empties the deque, so the copy follows suit.
  task automatic set_capacity(logic [CAP_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_setting  = value;
    head_at      = 0;
    tail_at      = 0;
    empty_now    = 1'b1;
  endtask

  // Push values lean on the extremes now and then, otherwise fully random.
  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // Runs alternate between mostly pushes and mostly pops, so the deque swings
  // between full and empty instead of hovering near the middle.
  task automatic queue_random(int count);
    bit push_lean;
    int run_left;
    push_lean = 1'b1;
    run_left  = 0;
    repeat (count) begin
      if (run_left == 0) begin
        push_lean = ~push_lean;
        run_left  = $urandom_range(2, 12);
      end
      run_left--;
      if ($urandom_range(0, 99) < (push_lean ? 80 : 20))
        queue_op($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_value());
      else
        queue_op($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, pick_value());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0] phase_caps [10] = '{8, 3, 15, 1, 5, 0, 2, 8, 6, 4};
  int               drain_cycles;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacity of eight: pops on an empty deque, pushes at both ends
    // with the extreme values, then pops back down to empty and one more.
    queue_op(OP_POP_FRONT,  32'h1234_5678);
    queue_op(OP_POP_REAR,   32'h0);
    queue_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    queue_op(OP_PUSH_REAR,  32'h8000_0000);
    queue_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    queue_op(OP_PUSH_REAR,  32'h0);
    queue_op(OP_POP_FRONT,  32'h0);
    queue_op(OP_POP_REAR,   32'h0);
    queue_op(OP_POP_REAR,   32'h0);
    queue_op(OP_POP_FRONT,  32'h0);
    queue_op(OP_POP_REAR,   32'hFFFF_FFFF);
    wait_idle();

    // Capacity two: fill it, overflow at the rear, then drain from both ends.
    set_capacity(2);
    queue_op(OP_PUSH_FRONT, 32'hA5A5_A5A5);
    queue_op(OP_PUSH_REAR,  32'h5A5A_5A5A);
    queue_op(OP_PUSH_REAR,  32'hDEAD_BEEF);
    queue_op(OP_POP_REAR,   32'h0);
    queue_op(OP_POP_FRONT,  32'h0);
    wait_idle();

    // Capacity one: the single entry is full at once.
    set_capacity(1);
    queue_op(OP_PUSH_REAR,  32'h0000_0001);
    queue_op(OP_PUSH_FRONT, 32'h0000_0002);
    queue_op(OP_POP_FRONT,  32'h0);
    queue_op(OP_POP_REAR,   32'h0);
    wait_idle();

    // A capacity of zero must behave exactly like one.
    set_capacity(0);
    queue_op(OP_PUSH_FRONT, 32'h8000_0001);
    queue_op(OP_PUSH_REAR,  32'h7FFF_FFFE);
    queue_op(OP_POP_REAR,   32'h0);
    wait_idle();

    // Random phases over a spread of capacities, including values above the
    // built depth. Two phases run without gaps; two hold the receiver off.
    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p]);
      steady = (p == 3 || p == 7);
      queue_random(125);
      if (p == 1 || p == 6) hold_requests++;
      wait_idle();
    end

    // Let the output settle, with a bound in case a result never shows up.
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("ERROR: %0d predicted result beats never arrived", expected_results.size());
      mismatch_count += expected_results.size();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
